// ===== rtl/core/etp_pkg.sv =====
// ----------------------------------------------------------------------------
// etp_pkg
// Types, command codes and constants shared by the elapsed-time timer pool.
// ----------------------------------------------------------------------------
package etp_pkg;

	localparam int TIMER_COUNT_DEF = 4;
	localparam int TICK_BITS       = 8;
	localparam int UPT_BITS        = 11;
	localparam int CMD_BITS        = 3;
	localparam int HANDLE_BITS     = 3;
	localparam int TOTAL_BITS      = 32;
	localparam int PROD_BITS       = TICK_BITS + UPT_BITS;

	localparam logic [UPT_BITS-1:0] UPT_RESET = UPT_BITS'(64);

	localparam logic [CMD_BITS-1:0] CMD_ACQUIRE = 3'd0;
	localparam logic [CMD_BITS-1:0] CMD_RESET   = 3'd1;
	localparam logic [CMD_BITS-1:0] CMD_RD_USEC = 3'd2;
	localparam logic [CMD_BITS-1:0] CMD_RD_MSEC = 3'd3;
	localparam logic [CMD_BITS-1:0] CMD_RD_SEC  = 3'd4;
	localparam logic [CMD_BITS-1:0] CMD_REFRESH = 3'd5;

	// quotient by reciprocal: floor(2^32 / divisor), then one correction step
	localparam int RECIP_BITS = 23;
	localparam int DIVR_BITS  = 20;
	localparam logic [RECIP_BITS-1:0] MSEC_RECIP    = 23'd4294967;
	localparam logic [RECIP_BITS-1:0] SEC_RECIP     = 23'd4294;
	localparam logic [DIVR_BITS-1:0]  USEC_PER_MSEC = 20'd1000;
	localparam logic [DIVR_BITS-1:0]  USEC_PER_SEC  = 20'd1000000;

	typedef struct packed {
		logic [CMD_BITS-1:0]    command;
		logic [HANDLE_BITS-1:0] timer;
		logic [TICK_BITS-1:0]   counter_now;
	} in_item_t;

	typedef struct packed {
		logic [TOTAL_BITS-1:0]  value;
		logic [HANDLE_BITS-1:0] handle;
	} out_item_t;

	typedef struct packed {
		logic [TOTAL_BITS-1:0] total;
		logic [TICK_BITS-1:0]  tick;
	} entry_t;

	typedef struct packed {
		logic start;
		logic to_sec;
	} div_req_t;

endpackage

// ===== rtl/core/etp_mem.sv =====
// ----------------------------------------------------------------------------
// etp_mem
// Timer state memory: one write port, one read port, registered read data.
// Entries read as zero until first written.
// ----------------------------------------------------------------------------
module etp_mem #(
	parameter int DEPTH = etp_pkg::TIMER_COUNT_DEF,
	parameter int IDX_W = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [IDX_W-1:0]  waddr,
	input  etp_pkg::entry_t   wdata,
	input  logic              re,
	input  logic [IDX_W-1:0]  raddr,
	output etp_pkg::entry_t   rdata
);
	import etp_pkg::*;

	entry_t           mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	entry_t           rd_q;
	logic             rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_vld_q <= vld_q[raddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

// ===== rtl/core/etp_div.sv =====
// ----------------------------------------------------------------------------
// etp_div
// Three-stage divide of a microsecond total by 1000 or 1000000 through a
// reciprocal multiply and one remainder correction.
// ----------------------------------------------------------------------------
module etp_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  etp_pkg::div_req_t            req,
	input  logic [etp_pkg::TOTAL_BITS-1:0] x,
	output logic                         done,
	output logic [etp_pkg::TOTAL_BITS-1:0] q
);
	import etp_pkg::*;

	localparam int PBITS = TOTAL_BITS + RECIP_BITS;

	logic                  v_s1, v_s2, v_s3;
	logic [TOTAL_BITS-1:0] x_s1, r_s2, q_s3;
	logic [RECIP_BITS-1:0] q0_s1, q0_s2;
	logic [DIVR_BITS-1:0]  k_s1, k_s2;
	logic [RECIP_BITS-1:0] recip;
	logic [PBITS-1:0]      prod;
	logic [TOTAL_BITS-1:0] qk;

	assign recip = req.to_sec ? SEC_RECIP : MSEC_RECIP;
	assign prod  = x * recip;
	assign qk    = {{(TOTAL_BITS-RECIP_BITS){1'b0}}, q0_s1}
		* {{(TOTAL_BITS-DIVR_BITS){1'b0}}, k_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s1  <= x;
		q0_s1 <= prod[PBITS-1:TOTAL_BITS];
		k_s1  <= req.to_sec ? USEC_PER_SEC : USEC_PER_MSEC;
		r_s2  <= x_s1 - qk;
		q0_s2 <= q0_s1;
		k_s2  <= k_s1;
		q_s3  <= (r_s2 >= {{(TOTAL_BITS-DIVR_BITS){1'b0}}, k_s2})
			? TOTAL_BITS'(q0_s2) + TOTAL_BITS'(1) : TOTAL_BITS'(q0_s2);
	end

	assign done = v_s3;
	assign q    = q_s3;

endmodule

// ===== rtl/core/elapsed_time_timer_pool.sv =====
// ----------------------------------------------------------------------------
// elapsed_time_timer_pool
// Pool of elapsed-time timers following a sampled 8-bit tick counter.
// ----------------------------------------------------------------------------
// Path: acquire, reset and no-timer items go straight to S_FIN; read usec
//   goes S_RD, S_WB; msec and sec add S_DIV; refresh runs S_RD, S_WB per timer.
// Throughput: one item at a time; the next item is taken once the result moves
//   to the output register. Each timer update is a read-modify-write of the
//   state memory (a read, then an update written back in S_WB).
// Reset: all timers read as zero, no handles given out, usec_per_tick is 64.
// ----------------------------------------------------------------------------
module elapsed_time_timer_pool #(
	parameter int TIMER_COUNT = etp_pkg::TIMER_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  etp_pkg::in_item_t             in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output etp_pkg::out_item_t            out_item,
	input  logic                          cfg_we,
	input  logic [etp_pkg::UPT_BITS-1:0]  cfg_data
);
	import etp_pkg::*;

	localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
	localparam logic [HANDLE_BITS-1:0] NO_TIMER = HANDLE_BITS'(TIMER_COUNT);
	localparam logic [IDX_W-1:0]       LAST_IDX = IDX_W'(TIMER_COUNT - 1);

	typedef enum logic [2:0] {S_IDLE, S_RD, S_WB, S_DIV, S_FIN} state_t;

	state_t                 state_q;
	logic [CMD_BITS-1:0]    cmd_q;
	logic [IDX_W-1:0]       idx_q;
	logic [TICK_BITS-1:0]   now_q;
	logic [UPT_BITS-1:0]    upt_q;
	logic [HANDLE_BITS-1:0] handed_q;
	logic [HANDLE_BITS-1:0] hnd_q;
	logic [PROD_BITS-1:0]   prod_q;
	logic [TOTAL_BITS-1:0]  tot_q;
	logic [TOTAL_BITS-1:0]  val_q;
	logic                   out_valid_q;
	out_item_t              out_item_q;

	logic                   accept;
	logic                   tmr_ok;
	logic                   have_free;
	logic [TICK_BITS-1:0]   delta;
	logic [TOTAL_BITS-1:0]  new_total;
	logic                   mem_we, mem_re;
	logic [IDX_W-1:0]       mem_waddr, mem_raddr;
	entry_t                 mem_wdata, mem_rdata;
	div_req_t               div_req;
	logic                   div_done;
	logic [TOTAL_BITS-1:0]  div_q;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign tmr_ok    = in_item.timer < NO_TIMER;
	assign have_free = handed_q < NO_TIMER;
	assign delta     = now_q - mem_rdata.tick;
	assign new_total = tot_q + TOTAL_BITS'(prod_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = '{total: new_total, tick: now_q};
		mem_re    = 1'b0;
		mem_raddr = '0;
		if (accept) begin
			case (in_item.command)
				CMD_ACQUIRE: begin
					mem_we    = have_free;
					mem_waddr = handed_q[IDX_W-1:0];
					mem_wdata = '{total: '0, tick: in_item.counter_now};
				end
				CMD_RESET: begin
					mem_we    = tmr_ok;
					mem_waddr = in_item.timer[IDX_W-1:0];
					mem_wdata = '{total: '0, tick: in_item.counter_now};
				end
				CMD_RD_USEC, CMD_RD_MSEC, CMD_RD_SEC: begin
					mem_re    = tmr_ok;
					mem_raddr = in_item.timer[IDX_W-1:0];
				end
				CMD_REFRESH: begin
					mem_re    = 1'b1;
					mem_raddr = '0;
				end
				default: ;
			endcase
		end else if (state_q == S_WB) begin
			mem_we = 1'b1;
			if (cmd_q == CMD_REFRESH && idx_q != LAST_IDX) begin
				mem_re    = 1'b1;
				mem_raddr = idx_q + IDX_W'(1);
			end
		end
	end

	assign div_req.start  = (state_q == S_WB)
		&& (cmd_q == CMD_RD_MSEC || cmd_q == CMD_RD_SEC);
	assign div_req.to_sec = (cmd_q == CMD_RD_SEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upt_q <= UPT_RESET;
		end else if (cfg_we) begin
			upt_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			handed_q    <= '0;
			out_valid_q <= 1'b0;
			out_item_q  <= '0;
			cmd_q       <= '0;
			idx_q       <= '0;
			now_q       <= '0;
			hnd_q       <= '0;
			val_q       <= '0;
			prod_q      <= '0;
			tot_q       <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q <= in_item.command;
						now_q <= in_item.counter_now;
						idx_q <= (in_item.command == CMD_REFRESH)
							? '0 : in_item.timer[IDX_W-1:0];
						val_q <= '0;
						hnd_q <= NO_TIMER;
						state_q <= S_FIN;
						case (in_item.command)
							CMD_ACQUIRE: begin
								if (have_free) begin
									hnd_q    <= handed_q;
									handed_q <= handed_q + HANDLE_BITS'(1);
								end
							end
							CMD_RD_USEC, CMD_RD_MSEC, CMD_RD_SEC: begin
								if (tmr_ok) begin
									state_q <= S_RD;
								end
							end
							CMD_REFRESH: state_q <= S_RD;
							default: ;
						endcase
					end
				end
				S_RD: begin
					prod_q  <= delta * upt_q;
					tot_q   <= mem_rdata.total;
					state_q <= S_WB;
				end
				S_WB: begin
					case (cmd_q)
						CMD_RD_USEC: begin
							val_q   <= new_total;
							state_q <= S_FIN;
						end
						CMD_RD_MSEC, CMD_RD_SEC: state_q <= S_DIV;
						CMD_REFRESH: begin
							if (idx_q == LAST_IDX) begin
								state_q <= S_FIN;
							end else begin
								idx_q   <= idx_q + IDX_W'(1);
								state_q <= S_RD;
							end
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_DIV: begin
					if (div_done) begin
						val_q   <= div_q;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_item_q  <= '{value: val_q, handle: hnd_q};
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	etp_mem #(
		.DEPTH (TIMER_COUNT),
		.IDX_W (IDX_W)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.re     (mem_re),
		.raddr  (mem_raddr),
		.rdata  (mem_rdata)
	);

	etp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.x      (new_total),
		.done   (div_done),
		.q      (div_q)
	);

endmodule

// ===== rtl/core/etp_chk.sv =====
// ----------------------------------------------------------------------------
// etp_chk
// Port-level checks for the elapsed-time timer pool, bound to the top level.
// ----------------------------------------------------------------------------
module etp_chk #(
	parameter int TIMER_COUNT = etp_pkg::TIMER_COUNT_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input etp_pkg::in_item_t            in_item,
	input logic                         out_valid,
	input logic                         out_ready,
	input etp_pkg::out_item_t           out_item,
	input logic                         cfg_we,
	input logic [etp_pkg::UPT_BITS-1:0] cfg_data
);
	import etp_pkg::*;

	localparam logic [HANDLE_BITS-1:0] NO_TIMER = HANDLE_BITS'(TIMER_COUNT);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result item changed while stalled");

	a_handle_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.handle != NO_TIMER |-> out_item.value == '0)
		else $error("acquire result carries a nonzero value");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken while another is in flight");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid))
		else $error("input side went busy without an item");

endmodule

bind elapsed_time_timer_pool etp_chk #(.TIMER_COUNT(TIMER_COUNT)) u_etp_chk (.*);
